// ----- hdl/plc_pkg.sv -----
package plc_pkg;

	// default sizes of the block
	localparam int DEF_MAX_STRANDS       = 32;
	localparam int DEF_MAX_STRAND_POINTS = 4096;
	localparam int DEF_COORD_BITS        = 48;

	// fixed field widths
	localparam int TOL_W    = 47;
	localparam int IDX_W    = 5;
	localparam int RING_W   = 18;
	localparam int STATUS_W = 3;

	// chaining limits
	localparam int MIN_RING   = 3;
	localparam int MIN_STRAND = 2;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_FEW       = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_NOT_CHAIN = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_OPEN      = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_SHORT     = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_CAP       = 3'd5;

	// sequencer states
	typedef enum logic [2:0] {
		S_LOAD,
		S_CHECK,
		S_SCAN,
		S_EVAL,
		S_CLOSE,
		S_EMIT_WAIT,
		S_EMIT_OUT
	} plc_state_t;

	// commands from the sequencer to the datapath
	typedef struct packed {
		logic                load;
		logic                init;
		logic                scan_start;
		logic                scan_next;
		logic                take;
		logic                emit;
		logic                emit_err;
		logic [STATUS_W-1:0] err_code;
		logic                clear;
	} plc_cmd_t;

	// status from the datapath to the sequencer
	typedef struct packed {
		logic overflow;
		logic too_few;
		logic joined_all;
		logic scan_done;
		logic cand_used;
		logic match;
		logic closed;
		logic short_ring;
		logic emit_last;
	} plc_stat_t;

endpackage

// ----- hdl/plc_ctrl.sv -----
module plc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              set_end,
	input  plc_pkg::plc_stat_t stat,
	output plc_pkg::plc_cmd_t  cmd,
	output logic              busy
);
	import plc_pkg::*;

	plc_state_t state_q;
	plc_state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_LOAD: begin
				if (start && set_end) begin
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.overflow || stat.too_few) begin
					state_nxt = S_LOAD;
				end else begin
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.joined_all) begin
					state_nxt = S_CLOSE;
				end else if (stat.scan_done) begin
					state_nxt = S_LOAD;
				end else if (!stat.cand_used) begin
					state_nxt = S_EVAL;
				end
			end
			S_EVAL: begin
				state_nxt = S_SCAN;
			end
			S_CLOSE: begin
				if (!stat.closed || stat.short_ring) begin
					state_nxt = S_LOAD;
				end else begin
					state_nxt = S_EMIT_WAIT;
				end
			end
			S_EMIT_WAIT: begin
				state_nxt = S_EMIT_OUT;
			end
			S_EMIT_OUT: begin
				if (stat.emit_last) begin
					state_nxt = S_LOAD;
				end else begin
					state_nxt = S_EMIT_WAIT;
				end
			end
			default: begin
				state_nxt = S_LOAD;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			S_LOAD: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_CHECK: begin
				if (stat.overflow) begin
					cmd.emit_err = 1'b1;
					cmd.err_code = STAT_CAP;
					cmd.clear    = 1'b1;
				end else if (stat.too_few) begin
					cmd.emit_err = 1'b1;
					cmd.err_code = STAT_FEW;
					cmd.clear    = 1'b1;
				end else begin
					cmd.init = 1'b1;
				end
			end
			S_SCAN: begin
				if (stat.joined_all) begin
					cmd.scan_start = 1'b0;
				end else if (stat.scan_done) begin
					cmd.emit_err = 1'b1;
					cmd.err_code = STAT_NOT_CHAIN;
					cmd.clear    = 1'b1;
				end else if (stat.cand_used) begin
					cmd.scan_next = 1'b1;
				end
			end
			S_EVAL: begin
				if (stat.match) begin
					cmd.take       = 1'b1;
					cmd.scan_start = 1'b1;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			S_CLOSE: begin
				if (!stat.closed) begin
					cmd.emit_err = 1'b1;
					cmd.err_code = STAT_OPEN;
					cmd.clear    = 1'b1;
				end else if (stat.short_ring) begin
					cmd.emit_err = 1'b1;
					cmd.err_code = STAT_SHORT;
					cmd.clear    = 1'b1;
				end else begin
					cmd.scan_start = 1'b1;
				end
			end
			S_EMIT_WAIT: begin
				busy = 1'b1;
			end
			S_EMIT_OUT: begin
				cmd.emit      = 1'b1;
				cmd.scan_next = 1'b1;
				cmd.clear     = stat.emit_last;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// ----- hdl/plc_dp.sv -----
module plc_dp #(
	parameter int MAX_STRANDS       = plc_pkg::DEF_MAX_STRANDS,
	parameter int MAX_STRAND_POINTS = plc_pkg::DEF_MAX_STRAND_POINTS,
	parameter int COORD_BITS        = plc_pkg::DEF_COORD_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  plc_pkg::plc_cmd_t             cmd,
	output plc_pkg::plc_stat_t            stat,
	input  logic signed [COORD_BITS-1:0]  x,
	input  logic signed [COORD_BITS-1:0]  y,
	input  logic                          strand_end,
	input  logic                          set_end,
	input  logic                          tolerance_we,
	input  logic [plc_pkg::TOL_W-1:0]     tolerance,
	output logic                          result_strobe,
	output logic [plc_pkg::IDX_W-1:0]     strand_index,
	output logic                          reversed,
	output logic [plc_pkg::RING_W-1:0]    ring_vertices,
	output logic [plc_pkg::STATUS_W-1:0]  status,
	output logic                          last
);
	import plc_pkg::*;

	localparam int SIDX_W = $clog2(MAX_STRANDS);
	localparam int CNT_W  = $clog2(MAX_STRANDS + 1);
	localparam int PTS_W  = $clog2(MAX_STRAND_POINTS + 2);
	localparam int RC_W   = $clog2(MAX_STRANDS * (MAX_STRAND_POINTS + 1) + 1);
	localparam int CMP_W  = (COORD_BITS + 1 > TOL_W) ? COORD_BITS + 1 : TOL_W;

	localparam logic [PTS_W-1:0] PTS_MAX   = PTS_W'(MAX_STRAND_POINTS);
	localparam logic [PTS_W-1:0] PTS_ONE   = PTS_W'(1);
	localparam logic [PTS_W-1:0] PTS_MINS  = PTS_W'(MIN_STRAND);
	localparam logic [PTS_W-1:0] PTS_MINR  = PTS_W'(MIN_RING);
	localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_MINS  = CNT_W'(MIN_STRAND);
	localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(MAX_STRANDS);
	localparam logic [RC_W-1:0]  RC_ONE    = RC_W'(1);
	localparam logic [RC_W-1:0]  RC_SHORT  = RC_W'(MIN_RING + 1);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] hx;
		logic signed [COORD_BITS-1:0] hy;
		logic signed [COORD_BITS-1:0] tx;
		logic signed [COORD_BITS-1:0] ty;
		logic [PTS_W-1:0]             pts;
	} strand_t;

	typedef struct packed {
		logic              rev;
		logic [SIDX_W-1:0] idx;
	} order_t;

	// endpoint match within the square tolerance box
	function automatic logic near_1d(logic signed [COORD_BITS-1:0] a,
	                                 logic signed [COORD_BITS-1:0] b,
	                                 logic [TOL_W-1:0] tol);
		logic signed [COORD_BITS:0] d;
		logic [COORD_BITS:0]        m;
		d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		m = d[COORD_BITS] ? -d : d;
		return CMP_W'(m) <= CMP_W'(tol);
	endfunction

	logic [TOL_W-1:0] tol_q;

	// load state
	logic [CNT_W-1:0]              total_q;
	logic [PTS_W-1:0]              cur_pts_q;
	logic                          ovf_q;
	logic signed [COORD_BITS-1:0]  cur_hx_q;
	logic signed [COORD_BITS-1:0]  cur_hy_q;
	logic signed [COORD_BITS-1:0]  head0_x_q;
	logic signed [COORD_BITS-1:0]  head0_y_q;
	logic signed [COORD_BITS-1:0]  tail0_x_q;
	logic signed [COORD_BITS-1:0]  tail0_y_q;
	logic [PTS_W-1:0]              pts0_q;

	// chain state
	logic [MAX_STRANDS-1:0]        used_q;
	logic [CNT_W-1:0]              scan_q;
	logic [CNT_W-1:0]              joined_q;
	logic signed [COORD_BITS-1:0]  ex_q;
	logic signed [COORD_BITS-1:0]  ey_q;
	logic [RC_W-1:0]               count_q;

	// memories
	strand_t strand_mem [MAX_STRANDS];
	strand_t strand_rd_q;
	order_t  order_mem [MAX_STRANDS];
	order_t  order_rd_q;

	logic [PTS_W-1:0]             pts_nxt;
	logic                         commit;
	strand_t                      wr_entry;
	logic                         head_m;
	logic                         tail_m;
	logic [RC_W-1:0]              ring_cnt;
	logic [SIDX_W-1:0]            scan_idx;
	logic [SIDX_W-1:0]            ord_waddr;
	order_t                       ord_wdata;
	logic                         ord_we;

	assign scan_idx = scan_q[SIDX_W-1:0];

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (tolerance_we) begin
			tol_q <= tolerance;
		end
	end

	// vertex count and strand entry for this request
	always_comb begin
		pts_nxt = (cur_pts_q <= PTS_MAX) ? cur_pts_q + PTS_ONE : cur_pts_q;
		commit  = cmd.load && (strand_end || set_end) && (pts_nxt >= PTS_MINS);
		wr_entry.hx  = (cur_pts_q == '0) ? x : cur_hx_q;
		wr_entry.hy  = (cur_pts_q == '0) ? y : cur_hy_q;
		wr_entry.tx  = x;
		wr_entry.ty  = y;
		wr_entry.pts = pts_nxt;
	end

	// load control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			cur_pts_q <= '0;
			ovf_q     <= 1'b0;
		end else if (cmd.clear) begin
			total_q   <= '0;
			cur_pts_q <= '0;
			ovf_q     <= 1'b0;
		end else if (cmd.load) begin
			if (strand_end || set_end) begin
				cur_pts_q <= '0;
			end else begin
				cur_pts_q <= pts_nxt;
			end
			// strand too long or no slot left
			if ((pts_nxt > PTS_MAX) || (commit && total_q >= CNT_FULL)) begin
				ovf_q <= 1'b1;
			end
			if (commit && total_q < CNT_FULL) begin
				total_q <= total_q + CNT_ONE;
			end
		end
	end

	// current strand head and first stored strand
	always_ff @(posedge clk) begin
		if (cmd.load && cur_pts_q == '0) begin
			cur_hx_q <= x;
			cur_hy_q <= y;
		end
		if (commit && total_q == '0) begin
			head0_x_q <= wr_entry.hx;
			head0_y_q <= wr_entry.hy;
			tail0_x_q <= wr_entry.tx;
			tail0_y_q <= wr_entry.ty;
			pts0_q    <= wr_entry.pts;
		end
	end

	// strand memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (commit && total_q < CNT_FULL) begin
			strand_mem[total_q[SIDX_W-1:0]] <= wr_entry;
		end
		strand_rd_q <= strand_mem[scan_idx];
	end

	// candidate match against the chain end
	always_comb begin
		head_m = near_1d(strand_rd_q.hx, ex_q, tol_q) && near_1d(strand_rd_q.hy, ey_q, tol_q);
		tail_m = near_1d(strand_rd_q.tx, ex_q, tol_q) && near_1d(strand_rd_q.ty, ey_q, tol_q);
	end

	// order memory writes
	always_comb begin
		ord_we        = cmd.init || cmd.take;
		ord_waddr     = cmd.init ? '0 : joined_q[SIDX_W-1:0];
		ord_wdata.idx = cmd.init ? '0 : scan_idx;
		ord_wdata.rev = cmd.init ? 1'b0 : !head_m;
	end

	always_ff @(posedge clk) begin
		if (ord_we) begin
			order_mem[ord_waddr] <= ord_wdata;
		end
		order_rd_q <= order_mem[scan_idx];
	end

	// scan pointer, joined count and used marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			scan_q   <= '0;
			joined_q <= '0;
		end else begin
			if (cmd.clear) begin
				used_q <= '0;
			end else if (cmd.init) begin
				used_q <= {{(MAX_STRANDS-1){1'b0}}, 1'b1};
			end else if (cmd.take) begin
				used_q[scan_idx] <= 1'b1;
			end
			if (cmd.init || cmd.scan_start) begin
				scan_q <= '0;
			end else if (cmd.scan_next) begin
				scan_q <= scan_q + CNT_ONE;
			end
			if (cmd.init) begin
				joined_q <= CNT_ONE;
			end else if (cmd.take) begin
				joined_q <= joined_q + CNT_ONE;
			end
		end
	end

	// chain end and running vertex count
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			ex_q    <= tail0_x_q;
			ey_q    <= tail0_y_q;
			count_q <= RC_W'(pts0_q);
		end else if (cmd.take) begin
			ex_q    <= head_m ? strand_rd_q.tx : strand_rd_q.hx;
			ey_q    <= head_m ? strand_rd_q.ty : strand_rd_q.hy;
			count_q <= count_q + RC_W'(strand_rd_q.pts) - RC_ONE;
		end
	end

	assign ring_cnt = count_q - RC_ONE;

	// status toward the sequencer
	always_comb begin
		stat.overflow   = ovf_q;
		stat.too_few    = (total_q < CNT_MINS) && ((total_q == '0) || (pts0_q < PTS_MINR));
		stat.joined_all = (joined_q == total_q);
		stat.scan_done  = (scan_q == total_q);
		stat.cand_used  = used_q[scan_idx];
		stat.match      = head_m || tail_m;
		stat.closed     = near_1d(head0_x_q, ex_q, tol_q) && near_1d(head0_y_q, ey_q, tol_q);
		stat.short_ring = (count_q < RC_SHORT);
		stat.emit_last  = ((scan_q + CNT_ONE) == total_q);
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= cmd.emit || cmd.emit_err;
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			strand_index  <= '0;
			reversed      <= 1'b0;
			ring_vertices <= '0;
			status        <= cmd.err_code;
			last          <= 1'b1;
		end else if (cmd.emit) begin
			strand_index  <= IDX_W'(order_rd_q.idx);
			reversed      <= order_rd_q.rev;
			ring_vertices <= stat.emit_last ? RING_W'(ring_cnt) : '0;
			status        <= STAT_OK;
			last          <= stat.emit_last;
		end
	end

endmodule

// ----- hdl/polyline_strand_ring_chainer.sv -----
// Vertices load one per cycle while busy is low. After the set_end vertex an early error
// result is registered from S_CHECK, else the first result follows the chaining search:
// S_SCAN skips used slots, S_EVAL tests unused ones (one memory read port), restarting
// from slot 0 after each joined strand; results then leave via S_EMIT_WAIT, S_EMIT_OUT.
// busy is high from the set_end vertex until the last result is issued.
// arst_n clears all control state and the tolerance; the receiver cannot stall.
module polyline_strand_ring_chainer #(
	parameter int MAX_STRANDS       = plc_pkg::DEF_MAX_STRANDS,
	parameter int MAX_STRAND_POINTS = plc_pkg::DEF_MAX_STRAND_POINTS,
	parameter int COORD_BITS        = plc_pkg::DEF_COORD_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_BITS-1:0]  x,
	input  logic signed [COORD_BITS-1:0]  y,
	input  logic                          strand_end,
	input  logic                          set_end,
	input  logic                          tolerance_we,
	input  logic [plc_pkg::TOL_W-1:0]     tolerance,
	output logic                          result_strobe,
	output logic [plc_pkg::IDX_W-1:0]     strand_index,
	output logic                          reversed,
	output logic [plc_pkg::RING_W-1:0]    ring_vertices,
	output logic [plc_pkg::STATUS_W-1:0]  status,
	output logic                          last
);
	import plc_pkg::*;

	plc_cmd_t  cmd;
	plc_stat_t stat;

	// sequencer
	plc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.set_end (set_end),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy)
	);

	// strand store and chaining datapath
	plc_dp #(
		.MAX_STRANDS       (MAX_STRANDS),
		.MAX_STRAND_POINTS (MAX_STRAND_POINTS),
		.COORD_BITS        (COORD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.x             (x),
		.y             (y),
		.strand_end    (strand_end),
		.set_end       (set_end),
		.tolerance_we  (tolerance_we),
		.tolerance     (tolerance),
		.result_strobe (result_strobe),
		.strand_index  (strand_index),
		.reversed      (reversed),
		.ring_vertices (ring_vertices),
		.status        (status),
		.last          (last)
	);

endmodule
